// ===== hw/rtl/dsv_field_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the delimiter-separated field tokenizer
// Shorthand for clocked assertions that use the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef DSV_FIELD_TOKENIZER_MACROS_SVH
`define DSV_FIELD_TOKENIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSVTOK_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsv_field_tokenizer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSVTOK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsv_field_tokenizer: next-cycle check failed");

`endif

// ===== hw/rtl/dsvtok_pkg.sv =====
// ----------------------------------------------------------------------------
// Field tokenizer package
// Shared constants and types of the delimiter-separated field tokenizer.
// ----------------------------------------------------------------------------
package dsvtok_pkg;

    localparam int SPACE_COUNT_BITS = 16;
    localparam int SPACES_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'h22;
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h2C;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [SPACES_W-1:0] spaces;
        logic [BYTE_W-1:0]   data;
        logic                ovf;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] quote;
        logic [BYTE_W-1:0] delim;
    } cfg_t;

    typedef struct packed {
        logic res_vld;
        logic can_take;
    } status_t;

endpackage

// ===== hw/rtl/dsvtok_parse.sv =====
// ----------------------------------------------------------------------------
// Field tokenizer parse stage
// Holds the parse state and a pair of result registers, and turns one text
// byte per cycle, while can_take is high, into up to two result transactions.
// ----------------------------------------------------------------------------
`include "dsv_field_tokenizer_macros.svh"

module dsvtok_parse (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsvtok_pkg::cfg_t              cfg,
    input  logic                          take,
    input  logic [dsvtok_pkg::BYTE_W-1:0] byte_in,
    input  logic                          pop,
    output dsvtok_pkg::status_t           status,
    output dsvtok_pkg::result_t           res
);

    localparam int SCB = dsvtok_pkg::SPACE_COUNT_BITS;
    localparam int SPC_W = (SCB > dsvtok_pkg::SPACES_W) ? SCB : dsvtok_pkg::SPACES_W;
    localparam logic [SPC_W-1:0] OUT_SPACE_MAX = SPC_W'((64'd1 << dsvtok_pkg::SPACES_W) - 64'd1);

    typedef enum logic [1:0] {
        MODE_START,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_AFTERQ
    } mode_t;

    typedef struct packed {
        logic                fire;
        logic [SCB-1:0]      held;
        logic                hovf;
        dsvtok_pkg::result_t res;
    } emit_t;

    typedef struct packed {
        logic [1:0]          cnt;
        dsvtok_pkg::result_t r0;
        dsvtok_pkg::result_t r1;
    } pair_t;

    function automatic dsvtok_pkg::result_t mark(input dsvtok_pkg::kind_t k);
        dsvtok_pkg::result_t r;
        r      = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic emit_t emit_data(input logic [SCB-1:0] held, input logic hovf,
                                        input logic [dsvtok_pkg::BYTE_W-1:0] c);
        emit_t            e;
        logic [SPC_W-1:0] wide;
        e      = '0;
        wide   = SPC_W'(held);
        e.held = held;
        e.hovf = hovf;
        if (c == dsvtok_pkg::CH_SPACE) begin
            if (&held) begin
                e.hovf = 1'b1;
            end
            else begin
                e.held = held + SCB'(1);
            end
        end
        else begin
            e.fire     = 1'b1;
            e.res.kind = dsvtok_pkg::KIND_DATA;
            e.res.data = c;
            if (wide > OUT_SPACE_MAX) begin
                e.res.spaces = '1;
                e.res.ovf    = 1'b1;
            end
            else begin
                e.res.spaces = dsvtok_pkg::SPACES_W'(wide);
                e.res.ovf    = hovf;
            end
            e.held = '0;
            e.hovf = 1'b0;
        end
        return e;
    endfunction

    function automatic pair_t push(input pair_t p, input dsvtok_pkg::result_t r);
        pair_t q;
        q = p;
        if (p.cnt == 2'd0) begin
            q.r0  = r;
            q.cnt = 2'd1;
        end
        else begin
            q.r1  = r;
            q.cnt = 2'd2;
        end
        return q;
    endfunction

    mode_t               mode_reg, mode_next;
    logic                touched_reg, touched_next;
    logic                open_reg, open_next;
    logic [SCB-1:0]      held_reg, held_next;
    logic                hovf_reg, hovf_next;
    logic [1:0]          cnt_reg, cnt_next;
    dsvtok_pkg::result_t res0_reg, res0_next;
    dsvtok_pkg::result_t res1_reg, res1_next;

    mode_t                         m_new;
    logic                          t_new, o_new, hv_new;
    logic [SCB-1:0]                h_new;
    pair_t                         p;
    emit_t                         e0, e1;
    logic                          is_q, is_le, is_d, is_sp, do_field, do_record;
    logic [dsvtok_pkg::BYTE_W-1:0] c;

    always_comb
    begin
        c      = byte_in;
        is_q   = (cfg.quote != dsvtok_pkg::CH_NUL) && (c == cfg.quote);
        is_le  = (c == dsvtok_pkg::CH_LF) || (c == dsvtok_pkg::CH_CR) ||
                 (c == dsvtok_pkg::CH_NUL);
        is_d   = (c == cfg.delim);
        is_sp  = (c == dsvtok_pkg::CH_SPACE);
        m_new  = mode_reg;
        t_new  = touched_reg;
        o_new  = open_reg;
        h_new  = held_reg;
        hv_new = hovf_reg;
        p      = '0;
        e0     = emit_data(held_reg, hovf_reg, c);
        e1     = '0;
        do_field  = 1'b0;
        do_record = 1'b0;

        unique case (mode_reg)
            MODE_START:
            begin
                if (is_q) begin
                    m_new = MODE_QUOTED;
                    t_new = 1'b1;
                    o_new = 1'b1;
                end
                else if (is_le) begin
                    do_record = 1'b1;
                end
                else if (is_d) begin
                    do_field = 1'b1;
                end
                else if (is_sp) begin
                    t_new = 1'b1;
                    o_new = 1'b1;
                end
                else begin
                    t_new = 1'b1;
                    o_new = 1'b1;
                    m_new = MODE_PLAIN;
                    h_new  = e0.held;
                    hv_new = e0.hovf;
                    p = push(p, e0.res);
                end
            end
            MODE_PLAIN:
            begin
                if (is_le) begin
                    do_record = 1'b1;
                end
                else if (is_d) begin
                    do_field = 1'b1;
                end
                else begin
                    h_new  = e0.held;
                    hv_new = e0.hovf;
                    if (e0.fire) begin
                        p = push(p, e0.res);
                    end
                end
            end
            MODE_QUOTED:
            begin
                if (is_q) begin
                    m_new = MODE_AFTERQ;
                end
                else if (c == dsvtok_pkg::CH_NUL) begin
                    do_record = 1'b1;
                end
                else begin
                    h_new  = e0.held;
                    hv_new = e0.hovf;
                    if (e0.fire) begin
                        p = push(p, e0.res);
                    end
                end
            end
            MODE_AFTERQ:
            begin
                if (is_q) begin
                    m_new  = MODE_QUOTED;
                    h_new  = e0.held;
                    hv_new = e0.hovf;
                    if (e0.fire) begin
                        p = push(p, e0.res);
                    end
                end
                else if (is_le) begin
                    do_record = 1'b1;
                end
                else if (is_d) begin
                    do_field = 1'b1;
                end
                else begin
                    m_new = MODE_QUOTED;
                    e0 = emit_data(held_reg, hovf_reg, cfg.quote);
                    e1 = emit_data(e0.held, e0.hovf, c);
                    h_new  = e1.held;
                    hv_new = e1.hovf;
                    if (e0.fire) begin
                        p = push(p, e0.res);
                    end
                    if (e1.fire) begin
                        p = push(p, e1.res);
                    end
                end
            end
            default:
            begin
                m_new = MODE_START;
            end
        endcase

        if (do_field) begin
            p      = push(p, mark(dsvtok_pkg::KIND_FIELD));
            o_new  = 1'b1;
        end
        if (do_record) begin
            if (touched_reg) begin
                p = push(p, mark(dsvtok_pkg::KIND_FIELD));
            end
            if (open_reg || touched_reg) begin
                p = push(p, mark(dsvtok_pkg::KIND_RECORD));
            end
            o_new = 1'b0;
        end
        if (do_field || do_record) begin
            m_new  = MODE_START;
            t_new  = 1'b0;
            h_new  = '0;
            hv_new = 1'b0;
        end

        if (p.cnt == 2'd2) begin
            p.r1.last = 1'b1;
        end
        else if (p.cnt == 2'd1) begin
            p.r0.last = 1'b1;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        touched_next = touched_reg;
        open_next    = open_reg;
        held_next    = held_reg;
        hovf_next    = hovf_reg;
        cnt_next     = cnt_reg;
        res0_next    = res0_reg;
        res1_next    = res1_reg;
        if (take) begin
            mode_next    = m_new;
            touched_next = t_new;
            open_next    = o_new;
            held_next    = h_new;
            hovf_next    = hv_new;
            cnt_next     = p.cnt;
            res0_next    = p.r0;
            res1_next    = p.r1;
        end
        else if (pop && (cnt_reg != 2'd0)) begin
            res0_next = res1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_START;
            touched_reg <= 1'b0;
            open_reg    <= 1'b0;
            held_reg    <= '0;
            hovf_reg    <= 1'b0;
            cnt_reg     <= 2'd0;
            res0_reg    <= '0;
            res1_reg    <= '0;
        end
        else begin
            mode_reg    <= mode_next;
            touched_reg <= touched_next;
            open_reg    <= open_next;
            held_reg    <= held_next;
            hovf_reg    <= hovf_next;
            cnt_reg     <= cnt_next;
            res0_reg    <= res0_next;
            res1_reg    <= res1_next;
        end
    end

    assign status.res_vld  = (cnt_reg != 2'd0);
    assign status.can_take = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign res             = res0_reg;

    `DSVTOK_ASSERT_SAME(a_mark_zero, (cnt_reg != 2'd0) && (res0_reg.kind != dsvtok_pkg::KIND_DATA), (res0_reg.spaces == '0) && (res0_reg.data == '0) && !res0_reg.ovf)
    `DSVTOK_ASSERT_SAME(a_pair_last, cnt_reg == 2'd2, !res0_reg.last && res1_reg.last)
    `DSVTOK_ASSERT_SAME(a_mode_touched, mode_reg != MODE_START, touched_reg)
    `DSVTOK_ASSERT_SAME(a_held_in_field, held_reg != '0, mode_reg != MODE_START)

endmodule

// ===== hw/rtl/dsv_field_tokenizer.sv =====
// Path: the input register holds a byte until the parse stage takes it, and
// its results are then registered in the single output register pair.
// Throughput: one byte per cycle while each byte gives at most one result and
// out_ready is high; a byte with two results holds the input while they drain.
// Reset: rst_n clears the parse state and results and restores quote and delimiter.
// ----------------------------------------------------------------------------
// Delimiter-separated field tokenizer
// Splits a byte stream into field data bytes, end-of-field and end-of-record
// marks, with quoted fields, space trimming and an APB-style register port.
// ----------------------------------------------------------------------------
`include "dsv_field_tokenizer_macros.svh"

module dsv_field_tokenizer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dsvtok_pkg::BYTE_W-1:0]   in_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      kind,
    output logic [dsvtok_pkg::SPACES_W-1:0] spaces_before,
    output logic [dsvtok_pkg::BYTE_W-1:0]   data_byte,
    output logic                            space_overflow,
    output logic                            last
);

    typedef enum logic {
        REG_QUOTE = 1'b0,
        REG_DELIM = 1'b1
    } reg_idx_t;

    logic [dsvtok_pkg::BYTE_W-1:0] quote_reg, quote_next;
    logic [dsvtok_pkg::BYTE_W-1:0] delim_reg, delim_next;
    logic                          in_vld_reg, in_vld_next;
    logic [dsvtok_pkg::BYTE_W-1:0] in_byte_reg, in_byte_next;

    reg_idx_t            reg_idx;
    logic                cfg_wr;
    logic                take;
    dsvtok_pkg::cfg_t    cfg;
    dsvtok_pkg::status_t status;
    dsvtok_pkg::result_t res;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        quote_next = quote_reg;
        delim_next = delim_reg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_QUOTE: quote_next = pwdata[dsvtok_pkg::BYTE_W-1:0];
                REG_DELIM: delim_next = pwdata[dsvtok_pkg::BYTE_W-1:0];
                default:   quote_next = quote_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_QUOTE: prdata = 32'(quote_reg);
            REG_DELIM: prdata = 32'(delim_reg);
            default:   prdata = '0;
        endcase
    end

    assign take     = in_vld_reg && status.can_take;
    assign in_ready = !in_vld_reg || take;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        if (in_ready) begin
            in_vld_next  = in_valid;
            in_byte_next = in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            quote_reg   <= dsvtok_pkg::QUOTE_RESET;
            delim_reg   <= dsvtok_pkg::DELIM_RESET;
            in_vld_reg  <= 1'b0;
            in_byte_reg <= '0;
        end
        else begin
            quote_reg   <= quote_next;
            delim_reg   <= delim_next;
            in_vld_reg  <= in_vld_next;
            in_byte_reg <= in_byte_next;
        end
    end

    assign cfg.quote = quote_reg;
    assign cfg.delim = delim_reg;

    dsvtok_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .take    (take),
        .byte_in (in_byte_reg),
        .pop     (out_ready),
        .status  (status),
        .res     (res)
    );

    assign out_valid      = status.res_vld;
    assign kind           = res.kind;
    assign spaces_before  = res.spaces;
    assign data_byte      = res.data;
    assign space_overflow = res.ovf;
    assign last           = res.last;

    `DSVTOK_ASSERT_NEXT(a_in_held, in_vld_reg && !take, in_vld_reg && $stable(in_byte_reg))
    `DSVTOK_ASSERT_SAME(a_take_room, take, !out_valid || out_ready)

endmodule

// ===== test/tb_dsv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Testbench for the delimiter-separated field tokenizer
// Streams text bytes through the block under several quote and delimiter
// settings: a short hand-picked sequence, a long run of held spaces inside
// one field, and random records with noise. Each byte is predicted in the
// testbench, and every output transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_dsv_field_tokenizer;

    import dsvtok_pkg::*;

    typedef enum logic [1:0] {
        AT_FIELD_START,
        IN_PLAIN,
        IN_QUOTED,
        AFTER_QUOTE
    } scan_mode_e;

    localparam logic [2:0] ADDR_QUOTE = 3'd0;
    localparam logic [2:0] ADDR_DELIM = 3'd4;
    localparam int NUM_SETTINGS = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int SPACE_RUN = 40;
    localparam int HOLD_CYCLES = 400;
    localparam longint unsigned SPACE_LIMIT = (64'd1 << SPACE_COUNT_BITS) - 1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] spaces_before;
    logic [7:0]  data_byte;
    logic        space_overflow;
    logic        last;

    logic [7:0] pending_bytes[$];
    result_t    tokens_due[$];
    result_t    step_tokens[$];

    logic [7:0] cfg_quote = QUOTE_RESET;
    logic [7:0] cfg_delim = DELIM_RESET;
    scan_mode_e scan_mode = AT_FIELD_START;
    logic       field_touched = 1'b0;
    logic       record_open = 1'b0;
    longint unsigned held_spaces = 0;
    logic       held_overflow = 1'b0;

    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   send_gap = 0;
    int   take_gap = 0;
    int   err_count = 0;
    int   bytes_sent = 0;
    int   tokens_checked = 0;

    logic [7:0] warmup [25] = '{
        8'h0A, 8'h20, "a", 8'h20, 8'h20, "b", 8'h20, ",", 8'h22, 8'h22,
        8'h22, 8'h22, "q", 8'h00, ",", 8'h0D, 8'h20, 8'h0A, 8'hFF, 8'h22,
        ",", 8'h22, 8'h0A, 8'h22, 8'h0D
    };

    // Upper byte is the quote, lower byte the delimiter.
    logic [15:0] cfg_plan [NUM_SETTINGS] = '{
        16'h222C, 16'h277C, 16'h0001, 16'hFF09,
        16'h2C2C, 16'h0A3B, 16'h20FF, 16'h0000
    };

    dsv_field_tokenizer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .spaces_before  (spaces_before),
        .data_byte      (data_byte),
        .space_overflow (space_overflow),
        .last           (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 9))
            0, 1: return CH_SPACE;
            2: return 8'($urandom_range(0, 255));
            3: return 8'($urandom_range(8'h30, 8'h39));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic logic is_line_end(logic [7:0] c);
        return c == CH_LF || c == CH_CR || c == CH_NUL;
    endfunction

    function automatic logic is_quote(logic [7:0] c);
        return cfg_quote != 8'h00 && c == cfg_quote;
    endfunction

    function automatic void add_token(kind_t k, logic [15:0] sp, logic [7:0] b, logic o);
        result_t r;
        if (step_tokens.size() >= 2)
            return;
        r.kind = k;
        r.spaces = sp;
        r.data = b;
        r.ovf = o;
        r.last = 1'b0;
        step_tokens.push_back(r);
    endfunction

    function automatic void emit_text(logic [7:0] c);
        longint unsigned sp;
        logic o;
        if (c == CH_SPACE)
        begin
            if (held_spaces >= SPACE_LIMIT)
                held_overflow = 1'b1;
            else
                held_spaces++;
            return;
        end
        sp = held_spaces;
        o = held_overflow;
        if (sp > 64'hFFFF)
        begin
            sp = 64'hFFFF;
            o = 1'b1;
        end
        add_token(KIND_DATA, sp[15:0], c, o);
        held_spaces = 0;
        held_overflow = 1'b0;
    endfunction

    function automatic void reset_field();
        scan_mode = AT_FIELD_START;
        field_touched = 1'b0;
        held_spaces = 0;
        held_overflow = 1'b0;
    endfunction

    function automatic void close_field();
        add_token(KIND_FIELD, 16'd0, 8'd0, 1'b0);
        reset_field();
        record_open = 1'b1;
    endfunction

    function automatic void close_record();
        if (field_touched)
            add_token(KIND_FIELD, 16'd0, 8'd0, 1'b0);
        if (record_open || field_touched)
            add_token(KIND_RECORD, 16'd0, 8'd0, 1'b0);
        reset_field();
        record_open = 1'b0;
    endfunction

    function automatic void predict_tokens(logic [7:0] c);
        step_tokens.delete();
        case (scan_mode)
            AT_FIELD_START:
            begin
                if (is_quote(c))
                begin
                    scan_mode = IN_QUOTED;
                    field_touched = 1'b1;
                    record_open = 1'b1;
                end
                else if (is_line_end(c))
                    close_record();
                else if (c == cfg_delim)
                    close_field();
                else if (c == CH_SPACE)
                begin
                    field_touched = 1'b1;
                    record_open = 1'b1;
                end
                else
                begin
                    field_touched = 1'b1;
                    record_open = 1'b1;
                    emit_text(c);
                    scan_mode = IN_PLAIN;
                end
            end
            IN_PLAIN:
            begin
                if (is_line_end(c))
                    close_record();
                else if (c == cfg_delim)
                    close_field();
                else
                    emit_text(c);
            end
            IN_QUOTED:
            begin
                if (is_quote(c))
                    scan_mode = AFTER_QUOTE;
                else if (c == CH_NUL)
                    close_record();
                else
                    emit_text(c);
            end
            default:
            begin
                if (is_quote(c))
                begin
                    emit_text(c);
                    scan_mode = IN_QUOTED;
                end
                else if (is_line_end(c))
                    close_record();
                else if (c == cfg_delim)
                    close_field();
                else
                begin
                    emit_text(cfg_quote);
                    emit_text(c);
                    scan_mode = IN_QUOTED;
                end
            end
        endcase
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            tokens_due.push_back(step_tokens[i]);
    endfunction

    task automatic reg_write(logic [2:0] addr, logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_QUOTE)
            cfg_quote = value;
        else
            cfg_delim = value;
    endtask

    task automatic add_record(logic [7:0] q, logic [7:0] d);
        int unsigned nfields;
        int unsigned len;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
                pending_bytes.push_back(d);
            repeat ($urandom_range(0, 2)) pending_bytes.push_back(CH_SPACE);
            len = $urandom_range(0, 6);
            if (q != 8'h00 && $urandom_range(0, 2) == 0)
            begin
                pending_bytes.push_back(q);
                repeat (len)
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            pending_bytes.push_back(q);
                            pending_bytes.push_back(q);
                        end
                        1: pending_bytes.push_back(d);
                        2: pending_bytes.push_back(CH_LF);
                        3:
                        begin
                            pending_bytes.push_back(q);
                            pending_bytes.push_back(pick_text());
                        end
                        default: pending_bytes.push_back(pick_text());
                    endcase
                end
                pending_bytes.push_back(q);
                repeat ($urandom_range(0, 1)) pending_bytes.push_back(CH_SPACE);
            end
            else
            begin
                repeat (len) pending_bytes.push_back(pick_text());
            end
        end
        if ($urandom_range(0, 4) == 0)
            pending_bytes.push_back(d);
        case ($urandom_range(0, 3))
            0: pending_bytes.push_back(CH_LF);
            1: pending_bytes.push_back(CH_CR);
            2: pending_bytes.push_back(CH_NUL);
            default:
            begin
                pending_bytes.push_back(CH_CR);
                pending_bytes.push_back(CH_LF);
            end
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || tokens_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                in_valid <= 1'b1;
                in_byte <= pending_bytes.pop_front();
                send_gap = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (take_gap > 0)
        begin
            take_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            take_gap = pick_gap();
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (in_valid && in_ready)
        begin
            predict_tokens(in_byte);
            bytes_sent++;
        end
        if (out_valid && out_ready)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("unexpected transaction: kind %0d data_byte %0h", kind, data_byte);
                err_count++;
            end
            else
            begin
                want = tokens_due.pop_front();
                tokens_checked++;
                if (kind !== want.kind)
                begin
                    $error("kind expected %0d actual %0d", want.kind, kind);
                    err_count++;
                end
                if (spaces_before !== want.spaces)
                begin
                    $error("spaces_before expected %0d actual %0d", want.spaces,
                           spaces_before);
                    err_count++;
                end
                if (data_byte !== want.data)
                begin
                    $error("data_byte expected %0h actual %0h", want.data, data_byte);
                    err_count++;
                end
                if (space_overflow !== want.ovf)
                begin
                    $error("space_overflow expected %0b actual %0b", want.ovf,
                           space_overflow);
                    err_count++;
                end
                if (last !== want.last)
                begin
                    $error("last expected %0b actual %0b", want.last, last);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_dsv_field_tokenizer: errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] quote_v;
        logic [7:0] delim_v;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        foreach (warmup[i])
            pending_bytes.push_back(warmup[i]);
        wait_idle();

        // Quoting off and a long run of held spaces inside one field.
        reg_write(ADDR_QUOTE, 8'h00);
        reg_write(ADDR_DELIM, 8'hFF);
        @(negedge clk);
        calm = 1'b1;
        pending_bytes.push_back("x");
        repeat (SPACE_RUN) pending_bytes.push_back(CH_SPACE);
        pending_bytes.push_back("z");
        pending_bytes.push_back(CH_SPACE);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(CH_NUL);
        pending_bytes.push_back(CH_NUL);
        wait_idle();

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            quote_v = cfg_plan[p][15:8];
            delim_v = cfg_plan[p][7:0];
            if (p == NUM_SETTINGS - 1)
            begin
                quote_v = 8'($urandom_range(0, 255));
                delim_v = 8'($urandom_range(1, 255));
            end
            reg_write(ADDR_QUOTE, quote_v);
            reg_write(ADDR_DELIM, delim_v);
            @(negedge clk);
            calm = ($urandom_range(0, 3) == 0);
            while (pending_bytes.size() < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 4))
                        pending_bytes.push_back(8'($urandom_range(0, 255)));
                else
                    add_record(quote_v, delim_v);
            end
            if (p == 2)
                hold_req = 1'b1;
            wait_idle();
        end

        $display("Run covered %0d bytes and %0d checked tokens over %0d delimiter settings,",
                 bytes_sent, tokens_checked, NUM_SETTINGS + 2);
        $display("including a long held-space run and a long output stall.");
        if (err_count == 0 && tokens_due.size() == 0)
            $display("tb_dsv_field_tokenizer: clean");
        else
            $display("tb_dsv_field_tokenizer: errors");
        $finish;
    end

endmodule
